/* rtl/yblk_pkg.sv */
// ----------------------------------------------------------------------------
// YMODEM block framer package
// Opcodes, framing byte codes, CRC helper and the request type that is
// queued between the front and back parts of the framer.
// ----------------------------------------------------------------------------
package yblk_pkg;

    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_FILL = 2'd1;
    localparam logic [1:0] OP_EOT  = 2'd2;

    localparam logic [7:0] SOH_CODE  = 8'h01;
    localparam logic [7:0] STX_CODE  = 8'h02;
    localparam logic [7:0] EOT_CODE  = 8'h04;
    localparam logic [7:0] FILL_CODE = 8'h1A;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam int unsigned COUNT_W = 11;
    localparam logic [COUNT_W-1:0] LONG_BLOCK_LEN  = 11'd1024;
    localparam logic [COUNT_W-1:0] SHORT_BLOCK_LEN = 11'd128;

    typedef struct packed {
        logic        is_eot;
        logic        has_hdr;
        logic        hdr_long;
        logic [7:0]  blk;
        logic [7:0]  data;
        logic        has_crc;
        logic [15:0] crc;
    } yblk_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } yblk_qstat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/ymodem_data_block_framer.sv */
// ----------------------------------------------------------------------------
// YMODEM data block framer
// Frames payload bytes into YMODEM data blocks with CRC-16 trailer.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while its four-entry request queue has
// room; the front end updates block number, fill count and CRC in the cycle
// of acceptance. The back end sends one framed byte per cycle unless m_ready
// stalls the output; an item yields one byte for a plain payload byte, four
// when it opens a block (start byte, block number, complement, byte) and
// three when it closes one (byte and two CRC bytes); EOT yields one. A
// 1024-byte block thus frames to 1029 bytes and a 128-byte block to 133.
// Results pass through a queue entry and then the registered output byte.
module ymodem_data_block_framer (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_run,
    output logic       m_block_done
);
    import yblk_pkg::*;

    logic        long_blocks_reg;
    logic        accept;
    logic        push;
    logic        pop;
    yblk_req_t   push_req;
    yblk_req_t   head;
    yblk_qstat_t qstat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_blocks_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            long_blocks_reg <= cfg_wr_data;
        end
    end

    assign s_ready = !qstat.full;
    assign accept  = s_valid && s_ready;

    yblk_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .long_blocks (long_blocks_reg),
        .accept      (accept),
        .opcode      (s_opcode),
        .data_byte   (s_data_byte),
        .push        (push),
        .push_req    (push_req)
    );

    yblk_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .stat     (qstat)
    );

    yblk_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .stat          (qstat),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_block_done  (m_block_done)
    );

    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_block_done |-> m_last_of_run)
        else $error("block_done without last_of_run");

    a_queue_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        !(qstat.full && qstat.empty))
        else $error("queue full and empty at once");

    a_pop_needs_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not idle after reset");

endmodule

/* rtl/yblk_front.sv */
// ----------------------------------------------------------------------------
// YMODEM framer front end
// Accepts items, keeps block number, fill count and running CRC, and turns
// each data, fill or EOT item into one framing request for the back end.
// ----------------------------------------------------------------------------
module yblk_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              long_blocks,
    input  logic              accept,
    input  logic [1:0]        opcode,
    input  logic [7:0]        data_byte,
    output logic              push,
    output yblk_pkg::yblk_req_t push_req
);
    import yblk_pkg::*;

    logic [7:0]         blk_num_reg,   blk_num_next;
    logic [COUNT_W-1:0] count_reg,     count_next;
    logic [15:0]        crc_reg,       crc_next;

    logic [COUNT_W-1:0] blk_len;
    logic [COUNT_W-1:0] count_inc;
    logic [7:0]         pay_byte;
    logic [15:0]        crc_new;
    logic               blk_full;
    logic               is_pay;

    assign blk_len   = long_blocks ? LONG_BLOCK_LEN : SHORT_BLOCK_LEN;
    assign pay_byte  = (opcode == OP_FILL) ? FILL_CODE : data_byte;
    assign crc_new   = crc_byte((count_reg == '0) ? 16'h0000 : crc_reg, pay_byte);
    assign count_inc = count_reg + 11'd1;
    assign blk_full  = (count_inc >= blk_len);
    assign is_pay    = (opcode == OP_DATA) || (opcode == OP_FILL);

    always_comb begin
        blk_num_next      = blk_num_reg;
        count_next        = count_reg;
        crc_next          = crc_reg;
        push              = 1'b0;
        push_req.is_eot   = (opcode == OP_EOT);
        push_req.has_hdr  = (count_reg == '0);
        push_req.hdr_long = long_blocks;
        push_req.blk      = blk_num_reg;
        push_req.data     = pay_byte;
        push_req.has_crc  = blk_full;
        push_req.crc      = crc_new;
        if (accept && (opcode == OP_EOT)) begin
            push         = 1'b1;
            blk_num_next = 8'd1;
            count_next   = '0;
            crc_next     = '0;
        end else if (accept && is_pay) begin
            push = 1'b1;
            if (blk_full) begin
                blk_num_next = blk_num_reg + 8'd1;
                count_next   = '0;
                crc_next     = '0;
            end else begin
                count_next = count_inc;
                crc_next   = crc_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_num_reg <= 8'd1;
            count_reg   <= '0;
            crc_reg     <= '0;
        end else begin
            blk_num_reg <= blk_num_next;
            count_reg   <= count_next;
            crc_reg     <= crc_next;
        end
    end

endmodule

/* rtl/yblk_queue.sv */
// ----------------------------------------------------------------------------
// YMODEM framer request queue
// Four-entry queue of framing requests between front and back end.
// ----------------------------------------------------------------------------
module yblk_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  yblk_pkg::yblk_req_t push_req,
    input  logic                pop,
    output yblk_pkg::yblk_req_t head,
    output yblk_pkg::yblk_qstat_t stat
);
    import yblk_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    yblk_req_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     cnt_reg,    cnt_next;
    logic               do_push;
    logic               do_pop;

    assign stat.full  = (cnt_reg == PTR_W'(0) + (PTR_W+1)'(DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* rtl/yblk_back.sv */
// ----------------------------------------------------------------------------
// YMODEM framer back end
// Walks the head request byte by byte: header, payload byte, CRC, and
// drives the registered output stage.
// ----------------------------------------------------------------------------
module yblk_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  yblk_pkg::yblk_req_t   head,
    input  yblk_pkg::yblk_qstat_t stat,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_out_byte,
    output logic                  m_last_of_run,
    output logic                  m_block_done
);
    import yblk_pkg::*;

    localparam logic [2:0] POS_START = 3'd0;
    localparam logic [2:0] POS_BLK   = 3'd1;
    localparam logic [2:0] POS_NBLK  = 3'd2;
    localparam logic [2:0] POS_DATA  = 3'd3;
    localparam logic [2:0] POS_CRCH  = 3'd4;
    localparam logic [2:0] POS_CRCL  = 3'd5;

    logic [2:0] pos_reg,   pos_next;
    logic       first_reg, first_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg,  byte_next;
    logic       last_reg,  last_next;
    logic       done_reg,  done_next;

    logic [2:0] pos;
    logic       emit;
    logic       run_end;

    assign pos  = first_reg ? ((head.has_hdr && !head.is_eot) ? POS_START : POS_DATA) : pos_reg;
    assign emit = !stat.empty && (!valid_reg || m_ready);

    always_comb begin
        case (pos)
            POS_START: byte_next = head.hdr_long ? STX_CODE : SOH_CODE;
            POS_BLK:   byte_next = head.blk;
            POS_NBLK:  byte_next = ~head.blk;
            POS_DATA:  byte_next = head.is_eot ? EOT_CODE : head.data;
            POS_CRCH:  byte_next = head.crc[15:8];
            POS_CRCL:  byte_next = head.crc[7:0];
            default:   byte_next = head.data;
        endcase
    end

    always_comb begin
        run_end    = head.is_eot || ((pos == POS_DATA) && !head.has_crc) || (pos == POS_CRCL);
        last_next  = run_end;
        done_next  = head.is_eot || (pos == POS_CRCL);
        pop        = emit && run_end;
        pos_next   = pos_reg;
        first_next = first_reg;
        if (emit) begin
            first_next = run_end;
            pos_next   = pos + 3'd1;
        end
        if (emit) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_START;
            first_reg <= 1'b1;
            valid_reg <= 1'b0;
        end else begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            done_reg <= done_next;
        end
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = byte_reg;
    assign m_last_of_run = last_reg;
    assign m_block_done  = done_reg;

endmodule
